[hw/rtl/fvc_pkg.sv]
`timescale 1ns / 1ps

package fvc_pkg;

    // Operand and result widths
    localparam int unsigned FLOW_W  = 16;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned ROOT_W  = SUM_W / 2;
    localparam int unsigned REM_W   = ROOT_W + 1;
    localparam int unsigned N_CELLS = ROOT_W;

    // Root at and above which blue saturates: 128 + (root >> 4) >= 255
    localparam logic [ROOT_W-1:0] BLUE_SAT_ROOT = ROOT_W'(2032);
    localparam logic [PIX_W-1:0]  PIX_MID       = PIX_W'(128);
    localparam logic [PIX_W-1:0]  PIX_MAX       = PIX_W'(255);

    // Payload carried from cell to cell of the square-root chain
    typedef struct packed {
        logic              valid;
        logic [SUM_W-1:0]  radicand;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  red;
    } cell_data_t;

endpackage

[hw/rtl/fvc_prep.sv]
`timescale 1ns / 1ps

module fvc_prep (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic signed [15:0]         flow_x,
    input  logic signed [15:0]         flow_y,
    input  logic                       flow_valid,
    output fvc_pkg::cell_data_t        out_data
);
    import fvc_pkg::*;

    logic                     sq_valid_reg;
    logic [SUM_W-2:0]         sq_x_reg;
    logic [SUM_W-2:0]         sq_y_reg;
    logic [PIX_W-1:0]         red_reg;
    logic [PIX_W-1:0]         green_reg;
    logic [FLOW_W-1:0]        abs_x;
    logic [FLOW_W-1:0]        abs_y;
    logic [PIX_W-1:0]         red_next;
    logic [PIX_W-1:0]         green_next;
    cell_data_t               out_reg;
    cell_data_t               out_next;

    // Map one Q8.8 component to 128 + 16 * v, floored and clamped
    function automatic logic [PIX_W-1:0] to_channel(input logic signed [FLOW_W-1:0] raw);
        logic signed [FLOW_W:0] v;
        logic [FLOW_W-5:0]      r;
        v = {raw[FLOW_W-1], raw} + (FLOW_W+1)'(2048);
        r = v[FLOW_W-1:4];
        if (v[FLOW_W]) begin
            return '0;
        end else if (r > (FLOW_W-4)'(255)) begin
            return PIX_MAX;
        end else begin
            return r[PIX_W-1:0];
        end
    endfunction

    // Magnitudes; 0x8000 gives 32768 which still fits 16 bits unsigned
    assign abs_x = flow_x[FLOW_W-1] ? FLOW_W'(-flow_x) : flow_x;
    assign abs_y = flow_y[FLOW_W-1] ? FLOW_W'(-flow_y) : flow_y;

    // Invalid vectors become neutral gray: zero length, mid channels
    assign red_next   = flow_valid ? to_channel(flow_x) : PIX_MID;
    assign green_next = flow_valid ? to_channel(flow_y) : PIX_MID;

    // Square each component
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (advance) begin
            sq_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_x_reg  <= flow_valid ? (SUM_W-1)'(abs_x * abs_x) : '0;
            sq_y_reg  <= flow_valid ? (SUM_W-1)'(abs_y * abs_y) : '0;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

    // Sum the squares and seed the root chain
    always_comb begin
        out_next.valid    = sq_valid_reg;
        out_next.radicand = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        out_next.rem      = '0;
        out_next.root     = '0;
        out_next.green    = green_reg;
        out_next.red      = red_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg.valid <= out_next.valid;
        end
        if (advance) begin
            out_reg.radicand <= out_next.radicand;
            out_reg.rem      <= out_next.rem;
            out_reg.root     <= out_next.root;
            out_reg.green    <= out_next.green;
            out_reg.red      <= out_next.red;
        end
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/fvc_root_cell.sv]
`timescale 1ns / 1ps

module fvc_root_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  fvc_pkg::cell_data_t in_data,
    output fvc_pkg::cell_data_t out_data
);
    import fvc_pkg::*;

    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic             take;
    cell_data_t       out_reg;
    cell_data_t       out_next;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_shift = {in_data.rem, in_data.radicand[SUM_W-1:SUM_W-2]};
    assign trial     = {1'b0, in_data.root, 2'b01};
    assign take      = (rem_shift >= trial);

    always_comb begin
        out_next          = in_data;
        out_next.radicand = {in_data.radicand[SUM_W-3:0], 2'b00};
        if (take) begin
            out_next.rem  = REM_W'(rem_shift - trial);
            out_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            out_next.rem  = REM_W'(rem_shift);
            out_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg.valid <= out_next.valid;
        end
        if (advance) begin
            out_reg.radicand <= out_next.radicand;
            out_reg.rem      <= out_next.rem;
            out_reg.root     <= out_next.root;
            out_reg.green    <= out_next.green;
            out_reg.red      <= out_next.red;
        end
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/flow_vector_to_color_pixel.sv]
`timescale 1ns / 1ps

// Channel   Ports                                         Direction
// s_        s_valid s_ready s_flow_x s_flow_y s_flow_valid  request in
// m_        m_valid m_ready m_blue_magnitude                result out
//           m_green_vertical m_red_horizontal
//
// One request is taken every cycle while the skid register is empty; the path is two
// front stages for squares and sum, sixteen square-root cells, one output register.
// Each root cell resolves one bit of the 16-bit root, which sets the depth.
// Reset clears valid bits only. A stalled output parks one result in a skid
// register; the chain freezes while that register is full.
module flow_vector_to_color_pixel (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_flow_x,
    input  logic signed [15:0] s_flow_y,
    input  logic               s_flow_valid,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_blue_magnitude,
    output logic [7:0]         m_green_vertical,
    output logic [7:0]         m_red_horizontal
);
    import fvc_pkg::*;

    cell_data_t       chain [0:N_CELLS];
    logic             advance;
    logic             push;
    logic [PIX_W-1:0] tail_blue;
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_blue_reg;
    logic [PIX_W-1:0] m_green_reg;
    logic [PIX_W-1:0] m_red_reg;
    logic             skid_valid_reg;
    logic [PIX_W-1:0] skid_blue_reg;
    logic [PIX_W-1:0] skid_green_reg;
    logic [PIX_W-1:0] skid_red_reg;

    // Move the whole chain whenever the skid register is free
    assign advance = !skid_valid_reg;
    assign s_ready = advance;
    assign push    = advance && chain[N_CELLS].valid;

    fvc_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_valid),
        .flow_x     (s_flow_x),
        .flow_y     (s_flow_y),
        .flow_valid (s_flow_valid),
        .out_data   (chain[0])
    );

    // One root bit per cell
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        fvc_root_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_data  (chain[i]),
            .out_data (chain[i+1])
        );
    end

    // Blue from the finished root, saturated
    assign tail_blue = (chain[N_CELLS].root >= BLUE_SAT_ROOT) ? PIX_MAX :
                       {1'b1, chain[N_CELLS].root[10:4]};

    // Output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_blue_reg  <= skid_blue_reg;
                m_green_reg <= skid_green_reg;
                m_red_reg   <= skid_red_reg;
            end else if (push) begin
                m_blue_reg  <= tail_blue;
                m_green_reg <= chain[N_CELLS].green;
                m_red_reg   <= chain[N_CELLS].red;
            end
        end else if (push) begin
            skid_blue_reg  <= tail_blue;
            skid_green_reg <= chain[N_CELLS].green;
            skid_red_reg   <= chain[N_CELLS].red;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_blue_magnitude = m_blue_reg;
    assign m_green_vertical = m_green_reg;
    assign m_red_horizontal = m_red_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a result while output is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_blue_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_blue_reg[PIX_W-1])
        else $error("blue below mid level");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    import fvc_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct {
        logic signed [FLOW_W-1:0] x;
        logic signed [FLOW_W-1:0] y;
        logic                     usable;
        bit                       typed;
        pixel_t                   pix;
    } flow_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [FLOW_W-1:0] s_flow_x;
    logic signed [FLOW_W-1:0] s_flow_y;
    logic                     s_flow_valid;
    logic                     m_valid;
    logic                     m_ready;
    logic [PIX_W-1:0]         m_blue_magnitude;
    logic [PIX_W-1:0]         m_green_vertical;
    logic [PIX_W-1:0]         m_red_horizontal;

    pixel_t expected_pixels[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_off_left;
    int     mismatch_count;
    int     orphan_count;
    int     request_count;
    int     result_count;
    int     invalid_count;
    int     blue_sat_count;
    int     clamp_count;

    // Directed vectors: zero, extremes, clamp and saturation edges, invalid flag
    flow_row_t dir_rows [21] = '{
        '{16'sd0,      16'sd0,      1'b1, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{16'sd32767,  16'sd32767,  1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{-16'sd32768, -16'sd32768, 1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{16'sd32767,  16'sd32767,  1'b1, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'sd32767,  -16'sd32768, 1'b1, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{-16'sd2048,  16'sd0,      1'b1, 1'b1, '{8'd255, 8'd128, 8'd0}},
        '{-16'sd2049,  16'sd0,      1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd0,      -16'sd2047,  1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd2047,   16'sd0,      1'b1, 1'b1, '{8'd255, 8'd128, 8'd255}},
        '{16'sd0,      16'sd2032,   1'b1, 1'b1, '{8'd255, 8'd255, 8'd128}},
        '{16'sd0,      16'sd2031,   1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd16,     16'sd0,      1'b1, 1'b1, '{8'd129, 8'd128, 8'd129}},
        '{-16'sd16,    -16'sd1,     1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd3,      16'sd4,      1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{-16'sd1,     -16'sd1,     1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd1200,   -16'sd1600,  1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd1200,   -16'sd1600,  1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}},
        '{-16'sd32768, 16'sd0,      1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd21845,  -16'sd21846, 1'b1, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{-16'sd21846, 16'sd21845,  1'b0, 1'b1, '{8'd128, 8'd128, 8'd128}}
    };

    flow_vector_to_color_pixel DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_flow_x         (s_flow_x),
        .s_flow_y         (s_flow_y),
        .s_flow_valid     (s_flow_valid),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_blue_magnitude (m_blue_magnitude),
        .m_green_vertical (m_green_vertical),
        .m_red_horizontal (m_red_horizontal)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Floor of the square root, one root bit per step
    function automatic logic [15:0] floor_root(logic [31:0] n);
        logic [33:0] rem;
        logic [33:0] trial;
        logic [15:0] root;
        rem  = '0;
        root = '0;
        for (int i = 15; i >= 0; i--) begin
            rem   = (rem << 2) | 34'((n >> (2 * i)) & 32'd3);
            trial = ({18'd0, root} << 2) | 34'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 16'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Offset a Q8.8 component to a byte: floor((2048 + raw) / 16), clamped
    function automatic logic [7:0] offset_channel(logic signed [15:0] raw);
        int v;
        v = 2048 + int'(raw);
        if (v < 0)
            return 8'd0;
        v = v >>> 4;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // Color a flow vector: red from x, green from y, blue from length
    function automatic pixel_t color_of_flow(logic signed [15:0] x, logic signed [15:0] y,
                                             logic usable);
        pixel_t     p;
        longint     ax;
        longint     ay;
        logic [15:0] len;
        int         b;
        if (!usable) begin
            p.blue  = 8'd128;
            p.green = 8'd128;
            p.red   = 8'd128;
            return p;
        end
        ax  = (x < 0) ? -longint'(x) : longint'(x);
        ay  = (y < 0) ? -longint'(y) : longint'(y);
        len = floor_root(32'(ax * ax + ay * ay));
        b   = 128 + int'(len >> 4);
        p.blue  = (b > 255) ? 8'd255 : 8'(b);
        p.green = offset_channel(y);
        p.red   = offset_channel(x);
        return p;
    endfunction

    // Random component: full range, near zero, near the clamp edges, extremes,
    // or near the blue saturation length
    function automatic logic signed [15:0] pick_component();
        int v;
        case ($urandom_range(0, 5))
            1: v = int'($urandom_range(0, 4400)) - 2200;
            2: v = ($urandom_range(0, 1) ? 2048 : -2048) + int'($urandom_range(0, 80)) - 40;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            4: begin
                v = int'($urandom_range(1990, 2070));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = int'($urandom);
        endcase
        return 16'(v);
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic drive_request(logic signed [15:0] x, logic signed [15:0] y, logic usable,
                                 pixel_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_flow_x     <= x;
        s_flow_y     <= y;
        s_flow_valid <= usable;
        do
            @(posedge aclk);
        while (!s_ready);
        expected_pixels.push_back(want);
        request_count++;
        if (!usable)
            invalid_count++;
        else if (want.blue == 8'd255)
            blue_sat_count++;
        if (usable && (want.red inside {8'd0, 8'd255} || want.green inside {8'd0, 8'd255}))
            clamp_count++;
    endtask

    // Pause the sender until every pending pixel has come out
    task automatic drain_pixels();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_burst(int count, int idle_pct, int stall_pct);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               usable;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            x      = pick_component();
            y      = pick_component();
            usable = ($urandom_range(0, 99) < 85);
            drive_request(x, y, usable, color_of_flow(x, y, usable));
        end
    endtask

    // Result side: random stalls, or a counted hold-off when one is armed
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare each delivered pixel with the oldest pending one
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
                orphan_count++;
                if (orphan_count + mismatch_count <= 10)
                    $display("%0t: pixel with none pending: b=%0d g=%0d r=%0d", $realtime,
                             m_blue_magnitude, m_green_vertical, m_red_horizontal);
            end else begin
                want = expected_pixels.pop_front();
                if (m_blue_magnitude !== want.blue || m_green_vertical !== want.green ||
                    m_red_horizontal !== want.red) begin
                    mismatch_count++;
                    if (orphan_count + mismatch_count <= 10)
                        $display("%0t: pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 $realtime, want.blue, want.green, want.red,
                                 m_blue_magnitude, m_green_vertical, m_red_horizontal);
                end
            end
        end
    end

    // Main sequence
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_flow_x       = '0;
        s_flow_y       = '0;
        s_flow_valid   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 0;
        mismatch_count = 0;
        orphan_count   = 0;
        request_count  = 0;
        result_count   = 0;
        invalid_count  = 0;
        blue_sat_count = 0;
        clamp_count    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed vectors
        foreach (dir_rows[i])
            drive_request(dir_rows[i].x, dir_rows[i].y, dir_rows[i].usable,
                          dir_rows[i].typed ? dir_rows[i].pix
                                            : color_of_flow(dir_rows[i].x, dir_rows[i].y,
                                                            dir_rows[i].usable));
        drain_pixels();

        // Full rate, with a long output hold-off at the start to back up the chain
        hold_off_left = 300;
        random_burst(240, 0, 0);
        drain_pixels();
        random_burst(230, 76, 0);
        drain_pixels();
        random_burst(240, 0, 76);
        drain_pixels();
        random_burst(240, 28, 28);
        drain_pixels();
        repeat (40) @(posedge aclk);

        $display("Sent %0d flow vectors (%0d invalid, %0d saturated blue, %0d clamped)",
                 request_count, invalid_count, blue_sat_count, clamp_count);
        $display("Checked %0d pixels under full rate, idle sender, stalled and mixed output",
                 result_count);
        if (mismatch_count == 0 && orphan_count == 0 && expected_pixels.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
